>>> design/rtc_scs_pkg.sv
// Shared types and constants for the serial RTC command shifter.
// No dependencies; imported by every module of the block.
package rtc_scs_pkg;

  // Default size of the shift register in bytes
  localparam int unsigned RegBytesDef = 8;

  // Payload widths
  localparam int unsigned PortW = 8;
  localparam int unsigned TimeW = 48;
  localparam int unsigned CodeW = 3;
  localparam int unsigned ScmdW = 5;
  localparam int unsigned CmdW  = 4;

  // Port byte bit positions
  localparam int unsigned StbBit = 3;
  localparam int unsigned ClkBit = 4;
  localparam int unsigned DatBit = 5;

  // Parallel code that selects the serial command
  localparam logic [CodeW-1:0] CodeSerial = 3'd7;

  // Strobe commands
  typedef enum logic [CmdW-1:0] {
    CMD_STOP  = 4'd0,
    CMD_SHIFT = 4'd1,
    CMD_HOLD  = 4'd2,
    CMD_LOAD  = 4'd3
  } cmd_e;

  // One input item
  typedef struct packed {
    logic [TimeW-1:0] time_now;
    logic [PortW-1:0] port_byte;
  } item_t;

endpackage

>>> design/rtc_scs_in_stage.sv
// Input register of the serial RTC command shifter.
// Depends on rtc_scs_pkg for the item type.
module rtc_scs_in_stage import rtc_scs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/rtc_scs_engine.sv
// Chip state of the serial RTC interface: edge detection, command decode,
// bit register and position. Depends on rtc_scs_pkg.
module rtc_scs_engine import rtc_scs_pkg::*; #(
  parameter int unsigned RegBytes = RegBytesDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  item_t item_i,
  output logic  data_out_o
);

  localparam int unsigned BitCount = RegBytes * 8;
  localparam int unsigned PosW     = $clog2(BitCount);
  localparam logic [PosW-1:0] PosLast = PosW'(BitCount - 1);
  localparam int unsigned MarkIdx  = (RegBytes - 7) * 8 + 7;

  logic [PortW-1:0]    prev_q, prev_d;
  logic [CodeW-1:0]    code_q, code_d;
  logic [ScmdW-1:0]    scmd_q, scmd_d;
  logic                shen_q, shen_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                obit_q, obit_d;
  logic [BitCount-1:0] bits_q, bits_d;

  logic [PortW-1:0]    pb;
  logic [TimeW-1:0]    tn;
  logic                stb_rise, clk_rise;
  logic [CmdW-1:0]     cmd;
  logic [BitCount-1:0] load_v;

  assign pb = item_i.port_byte;
  assign tn = item_i.time_now;

  assign stb_rise = pb[StbBit] && !prev_q[StbBit];
  assign clk_rise = pb[ClkBit] && !prev_q[ClkBit];
  assign cmd = (code_q == CodeSerial) ? scmd_q[CmdW-1:0] : {1'b0, code_q};

  // Register image after a load: time bytes at the top, bit-reversed per byte, and a marker bit in the byte below
  always_comb begin
    load_v = '0;
    for (int k = 0; k < 6; k++) begin
      for (int m = 0; m < 8; m++) begin
        load_v[(RegBytes - 6 + k) * 8 + m] = tn[47 - 8 * k - m];
      end
    end
    load_v[MarkIdx] = 1'b1;
  end

  always_comb begin
    prev_d = pb;
    code_d = code_q;
    scmd_d = scmd_q;
    shen_d = shen_q;
    pos_d  = pos_q;
    obit_d = obit_q;
    bits_d = bits_q;
    if (pb[StbBit]) begin
      if (stb_rise) begin
        unique case (cmd) inside
          CMD_STOP, CMD_HOLD: begin
            shen_d = 1'b0;
          end
          CMD_SHIFT: begin
            shen_d = 1'b1;
            pos_d  = PosLast;
            obit_d = bits_q[BitCount-1];
          end
          CMD_LOAD: begin
            shen_d = 1'b0;
            bits_d = load_v;
            obit_d = tn[0];
          end
          default: begin
          end
        endcase
      end
    end else if (pb[ClkBit]) begin
      if (clk_rise) begin
        if (code_q == CodeSerial) begin
          scmd_d = scmd_q >> 1;
        end
        if (shen_q && (pos_q != '0)) begin
          pos_d = pos_q - PosW'(1);
        end
        obit_d = bits_q[pos_d];
      end
    end else begin
      // Data write: latch code, feed serial command, store data bit
      code_d = pb[CodeW-1:0];
      if (pb[CodeW-1:0] == CodeSerial) begin
        scmd_d = {pb[DatBit], scmd_q[CmdW-1:0]};
      end
      bits_d[pos_q] = pb[DatBit];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      code_q <= '0;
      scmd_q <= '0;
      shen_q <= 1'b0;
      pos_q  <= '0;
      obit_q <= 1'b0;
      bits_q <= '0;
    end else if (advance_i) begin
      prev_q <= prev_d;
      code_q <= code_d;
      scmd_q <= scmd_d;
      shen_q <= shen_d;
      pos_q  <= pos_d;
      obit_q <= obit_d;
      bits_q <= bits_d;
    end
  end

  assign data_out_o = obit_d;

endmodule

>>> design/rtc_scs_out_stage.sv
// Result register of the serial RTC command shifter.
// Depends on rtc_scs_pkg only through the shared import convention.
module rtc_scs_out_stage import rtc_scs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic data_out_i,
  input  logic ready_i,
  output logic valid_o,
  output logic data_out_o
);

  logic valid_q, valid_d;
  logic data_q;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= data_out_i;
    end
  end

  assign valid_o    = valid_q;
  assign data_out_o = data_q;

endmodule

>>> design/rtc_scs_core.sv
// Top level of the serial RTC command shifter.
// Instantiates rtc_scs_in_stage, rtc_scs_engine and rtc_scs_out_stage; uses rtc_scs_pkg.
//
// Channel  | Dir | Signals                | Payload
// ---------+-----+------------------------+---------------------------------
// s_axis   | in  | tvalid tready tdata    | port_byte, time_now (56 bits)
// m_axis   | out | tvalid tready tdata    | data_out, zero padded (8 bits)
//
// One transfer in, one transfer out; an item can enter every cycle unless both stages are full and the output stalls.
// Each item passes the input register, then the state update into the
// result register. The input register refills while a result waits.
// Reset clears all chip state, including the bit register, at once.
// A stalled output holds one result and one queued item before tready drops.
module rtc_serial_command_shifter_core import rtc_scs_pkg::*; #(
  parameter int unsigned REG_BYTES = RegBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // [7:0] port_byte, [55:8] time_now
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [0] data_out, [7:1] zero
);

  item_t in_item, stage_item;
  logic  stage_valid;
  logic  advance;
  logic  next_bit;
  logic  out_bit;

  assign in_item.port_byte = s_axis_tdata_i[PortW-1:0];
  assign in_item.time_now  = s_axis_tdata_i[PortW+TimeW-1:PortW];

  // Move the held item into the result register when it is free
  assign advance = stage_valid && (!m_axis_tvalid_o || m_axis_tready_i);

  rtc_scs_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .item_i    (in_item),
    .advance_i (advance),
    .ready_o   (s_axis_tready_o),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  rtc_scs_engine #(
    .RegBytes (REG_BYTES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (stage_item),
    .data_out_o (next_bit)
  );

  rtc_scs_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .data_out_i (next_bit),
    .ready_i    (m_axis_tready_i),
    .valid_o    (m_axis_tvalid_o),
    .data_out_o (out_bit)
  );

  assign m_axis_tdata_o = {7'b0, out_bit};

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while both stages are full and stalled");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> stage_valid)
    else $error("accepted transfer not held in the input register");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(stage_valid))
    else $error("result appeared without a queued item");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for rtc_serial_command_shifter_core: drives port/time
// transfers and checks every serial output bit against an in-bench chip model.
// Depends on rtc_scs_pkg and the core top level only.
module testbench;
  import rtc_scs_pkg::*;

  localparam int unsigned REG_BYTES = RegBytesDef;
  localparam int unsigned BitCount  = REG_BYTES * 8;
  localparam int unsigned NumItems  = 1725;
  localparam int unsigned DrainAt   = 900;
  localparam int unsigned QuietLo   = 1200;
  localparam int unsigned QuietHi   = 1700;
  localparam int unsigned IdlePct   = 19;
  localparam int unsigned Limit     = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  item_t      in_item = '0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;

  rtc_serial_command_shifter_core #(.REG_BYTES(REG_BYTES)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Chip model state
  logic [PortW-1:0] chip_prev_byte = '0;
  logic [CodeW-1:0] chip_code      = '0;
  logic [ScmdW-1:0] chip_scmd      = '0;
  logic             chip_shift_en  = 1'b0;
  int unsigned      chip_pos       = 0;
  logic             chip_out_bit   = 1'b0;
  logic [7:0]       chip_reg [REG_BYTES] = '{default: '0};

  item_t       pending_items [$];
  logic        expected_dout [$];
  int unsigned n_items     = 0;
  int unsigned issued      = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  bit          in_fire     = 1'b0;
  bit          drain_hold  = 1'b0;
  bit          drain_done  = 1'b0;

  task automatic chip_run_command(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] tn);
    case (cmd)
      CMD_STOP, CMD_HOLD: begin
        chip_shift_en = 1'b0;
      end
      CMD_SHIFT: begin
        chip_shift_en = 1'b1;
        chip_pos      = BitCount - 1;
        chip_out_bit  = chip_reg[REG_BYTES-1][0];
      end
      CMD_LOAD: begin
        chip_shift_en = 1'b0;
        for (int i = 0; i < REG_BYTES; i++) chip_reg[i] = '0;
        for (int i = 0; i < 6; i++) chip_reg[REG_BYTES-6+i] = tn[40-8*i +: 8];
        // output bit is taken before the marker byte is set
        chip_out_bit = chip_reg[REG_BYTES-1][0];
        chip_reg[REG_BYTES-7] = 8'h01;
      end
      default: ;
    endcase
  endtask

  task automatic chip_step(input item_t it, output logic dout);
    logic [PortW-1:0] changed;
    logic [CmdW-1:0]  cmd;
    int unsigned      p;
    changed = it.port_byte ^ chip_prev_byte;
    chip_prev_byte = it.port_byte;
    if (it.port_byte[StbBit]) begin
      if (changed[StbBit]) begin
        cmd = (chip_code == CodeSerial) ? chip_scmd[CmdW-1:0] : CmdW'(chip_code);
        chip_run_command(cmd, it.time_now);
      end
    end else if (it.port_byte[ClkBit]) begin
      if (changed[ClkBit]) begin
        if (chip_code == CodeSerial) chip_scmd = chip_scmd >> 1;
        chip_pos = chip_pos % BitCount;
        if (chip_shift_en && chip_pos != 0) chip_pos--;
        p = chip_pos;
        chip_out_bit = chip_reg[p / 8][7 - (p % 8)];
      end
    end else begin
      chip_code = it.port_byte[CodeW-1:0];
      if (chip_code == CodeSerial) chip_scmd = {it.port_byte[DatBit], chip_scmd[CmdW-1:0]};
      p = chip_pos % BitCount;
      chip_reg[p / 8][7 - (p % 8)] = it.port_byte[DatBit];
    end
    dout = chip_out_bit;
  endtask

  function automatic logic [7:0] pack_port(logic [2:0] code, bit stb, bit clk, bit dat);
    logic [1:0] hi;
    hi = 2'($urandom);
    return {hi, dat, clk, stb, code};
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return TimeW'({$urandom, $urandom});
  endfunction

  task automatic push_item(input logic [7:0] pb, input logic [TimeW-1:0] tn);
    item_t it;
    it.port_byte = pb;
    it.time_now  = tn;
    pending_items.push_back(it);
    n_items++;
  endtask

  // Each rising clock is followed by a data write that drops the clock again
  task automatic push_clocks(input int unsigned n);
    repeat (n) begin
      push_item(pack_port(3'($urandom), 1'b0, 1'b1, 1'($urandom)), rand_time());
      push_item(pack_port(3'($urandom), 1'b0, 1'b0, 1'($urandom)), rand_time());
    end
  endtask

  function automatic bit roll_idle();
    if (cycle_count >= QuietLo && cycle_count < QuietHi) return 1'b0;
    return $urandom_range(0, 99) < IdlePct;
  endfunction

  // Sender: hold the current transfer until accepted, then advance
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= !roll_idle();
      if (!s_axis_tvalid_i || in_fire) begin
        if (issued == DrainAt && !drain_done) drain_hold = 1'b1;
        if (drain_hold && expected_dout.size() == 0) begin
          drain_hold = 1'b0;
          drain_done = 1'b1;
        end
        if (drain_hold || pending_items.size() == 0 || roll_idle()) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          in_item         <= pending_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          issued++;
        end
      end
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    logic exp_bit;
    cycle_count++;
    in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      chip_step(in_item, exp_bit);
      expected_dout.push_back(exp_bit);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_dout.size() == 0) begin
        $display("%0t: unexpected result, actual tdata %h", $realtime, m_axis_tdata_o);
        error_count++;
      end else begin
        exp_bit = expected_dout.pop_front();
        if (m_axis_tdata_o !== {7'd0, exp_bit}) begin
          $display("%0t: data_out mismatch, expected tdata %h, actual %h",
                   $realtime, {7'd0, exp_bit}, m_axis_tdata_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (Limit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [2:0]  code;
    int unsigned n;
    logic [TimeW-1:0] tn;

    // Directed: load, shift-out, stop/hold, both strobe and clock high, serial command
    push_item(8'h23, '0);                   // data 1 at position 0, code load
    push_item(8'h08, '1);                   // rising strobe: load all-ones time
    push_item(8'h00, '0);
    push_item(8'h10, '0);                   // rising clock without shift mode
    push_item(8'h00, '1);
    push_item(8'h01, '0);                   // code shift
    push_item(8'h09, '0);                   // rising strobe: start from last bit
    push_item(8'h01, '0);
    push_item(8'h11, '0);                   // step down
    push_item(8'h21, '1);
    push_item(8'h11, '0);
    push_item(8'hFF, '1);                   // strobe and clock together: strobe wins
    push_item(8'hC0, '0);                   // upper bits ignored
    push_item(8'h08, '0);                   // stop
    push_item(8'h02, '0);
    push_item(8'h0A, '0);                   // hold
    push_item(8'h27, '0);                   // serial command 3, lsb first
    push_item(8'h17, '0);
    push_item(8'h27, '0);
    push_item(8'h17, '0);
    push_item(8'h07, '0);
    push_item(8'h17, '0);
    push_item(8'h07, '0);
    push_item(8'h17, '0);
    push_item(8'h0F, 48'h8000_0000_0001);   // strobe runs the serial command

    while (n_items < NumItems) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 4)) push_item(8'($urandom), rand_time());
        end
        2, 3: begin
          code = 3'($urandom);
          push_item(pack_port(code, 1'b0, 1'b0, 1'($urandom)), rand_time());
          push_item(pack_port(3'($urandom), 1'b1, 1'($urandom), 1'($urandom)), rand_time());
          push_item(pack_port(code, 1'b0, 1'b0, 1'($urandom)), rand_time());
        end
        4, 5: begin
          push_clocks($urandom_range(1, 8));
        end
        6, 7: begin
          // mostly four bits, sometimes a broken count
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 4;
          repeat (n) begin
            push_item(pack_port(CodeSerial, 1'b0, 1'b0, 1'($urandom)), rand_time());
            push_item(pack_port(3'($urandom), 1'b0, 1'b1, 1'($urandom)), rand_time());
          end
          push_item(pack_port(CodeSerial, 1'b0, 1'b0, 1'($urandom)), rand_time());
          push_item(pack_port(3'($urandom), 1'b1, 1'($urandom), 1'($urandom)), rand_time());
          push_clocks($urandom_range(1, 12));
        end
        8: begin
          tn = rand_time();
          push_item(pack_port(3'(CMD_LOAD), 1'b0, 1'b0, 1'($urandom)), tn);
          push_item(pack_port(3'($urandom), 1'b1, 1'($urandom), 1'($urandom)), tn);
          push_clocks($urandom_range(1, 6));
        end
        default: begin
          push_item(pack_port(3'(CMD_SHIFT), 1'b0, 1'b0, 1'($urandom)), rand_time());
          push_item(pack_port(3'($urandom), 1'b1, 1'($urandom), 1'($urandom)), rand_time());
          // occasionally run past position zero
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
          push_clocks(n);
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid_i || expected_dout.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
